[hdl/soa_pkg.sv]
// Shared constants, size-class tables and types of the slab object allocator.
// Used by every module of the allocator but soa_ram; depends on nothing.
`timescale 1ns / 1ps

package soa_pkg;

  localparam int DEF_NUM_PAGES    = 64;
  localparam int DEF_HEADER_BYTES = 64;
  localparam int DEF_MAX_OBJECTS  = 256;

  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = 12;
  localparam int ADDR_W      = 48;
  localparam int FRAME_W     = 36;
  localparam int SIZE_W      = 16;
  localparam int MAX_SIZE    = 1024;
  localparam int NUM_CLASSES = 7;
  localparam int CLASS_W     = 3;
  localparam int CHUNK_W     = 32;
  localparam int CHUNK_IW    = 5;

  localparam int CLASS_SIZE  [NUM_CLASSES] = '{16, 32, 64, 128, 256, 512, 1024};
  localparam int CLASS_ALIGN [NUM_CLASSES] = '{4, 4, 4, 4, 8, 8, 8};
  localparam int CLASS_SHIFT [NUM_CLASSES] = '{4, 5, 6, 7, 8, 9, 10};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  typedef struct packed {
    logic                hit;
    logic [CHUNK_IW-1:0] idx;
  } soa_scan_t;

endpackage

[hdl/soa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/soa_bit_scan.sv]
// Lowest-set-bit finder over one 32-bit chunk of free-slot flags.
// Depends on soa_pkg.
`timescale 1ns / 1ps

module soa_bit_scan (
  input  logic [soa_pkg::CHUNK_W-1:0] avail,
  output soa_pkg::soa_scan_t          result
);
  import soa_pkg::*;

  logic [CHUNK_W-1:0] lowest;

  always_comb begin
    lowest = avail & (~avail + CHUNK_W'(1));
    result.hit = |avail;
    for (int b = 0; b < CHUNK_IW; b++) begin
      result.idx[b] = 1'b0;
      for (int j = 0; j < CHUNK_W; j++) begin
        if (((j >> b) & 1) == 1) begin
          result.idx[b] = result.idx[b] | lowest[j];
        end
      end
    end
  end

endmodule

[hdl/slab_object_allocator.sv]
// Slab object allocator: control sequencer around one page-state RAM.
// Depends on soa_pkg, soa_ram and soa_bit_scan.
//
// Usage: write pool_base_frame on the cfg channel while idle. Items enter on
// in_valid/in_ready: opcode 0 allocates request_size bytes, opcode 1 frees
// free_address. Each item gives one result item on out_valid/out_ready with
// object_address and status. One item is worked at a time.
// Allocate scans the claimed pages, one RAM read per cycle, then searches
// the 32-bit bitmap chunks of the chosen page (at most MAX_OBJECTS/32,
// rounded up). A rejected size is reported without a page scan. Free does
// a RAM read, a slot check and a write back; a free outside the claimed
// pages is rejected without a RAM read.
// The page-state RAM holds owner class, used count and bitmap per page; a
// page row is written fresh when it is claimed, so no clearing pass follows
// reset. Reset clears the claimed-page count and the base register and
// empties the result register. When the receiver stalls, the result is held
// and the block takes the next item but does not finish it until the
// result register is free.
`timescale 1ns / 1ps

module slab_object_allocator #(
  parameter int NUM_PAGES    = soa_pkg::DEF_NUM_PAGES,
  parameter int HEADER_BYTES = soa_pkg::DEF_HEADER_BYTES,
  parameter int MAX_OBJECTS  = soa_pkg::DEF_MAX_OBJECTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [soa_pkg::FRAME_W-1:0]  pool_base_frame,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [soa_pkg::SIZE_W-1:0]   request_size,
  input  logic [soa_pkg::ADDR_W-1:0]   free_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [soa_pkg::ADDR_W-1:0]   object_address,
  output logic [1:0]                   status
);
  import soa_pkg::*;

  localparam int PW   = $clog2(NUM_PAGES);
  localparam int PCW  = $clog2(NUM_PAGES + 1);
  localparam int CNTW = $clog2(MAX_OBJECTS + 1);
  localparam int BW   = MAX_OBJECTS;
  localparam int IW   = $clog2(MAX_OBJECTS);
  localparam int NCH  = (MAX_OBJECTS + CHUNK_W - 1) / CHUNK_W;
  localparam int PADW = NCH * CHUNK_W;
  localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int RW   = CLASS_W + CNTW + BW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_BITS, S_FREE_RD, S_FREE_CHK, S_FREE_WR, S_DONE
  } state_t;

  state_t state;

  logic [CNTW-1:0]       cls_count [NUM_CLASSES];
  logic [PAGE_SHIFT-1:0] cls_start [NUM_CLASSES];

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_geom
    localparam int N0 = (8 * (PAGE_BYTES - HEADER_BYTES)) / (8 * CLASS_SIZE[g] + 1);
    localparam int N1 = (N0 > MAX_OBJECTS) ? MAX_OBJECTS : N0;
    localparam int O0 = HEADER_BYTES + (N1 + 4) / 8;
    localparam int AM = CLASS_ALIGN[g] - 1;
    localparam int O1 = ((O0 & AM) != 0) ? (O0 + AM + 1 - (O0 & AM)) : O0;
    localparam int N2 = (((O0 & AM) != 0) && (N1 > 0) &&
                         (O1 + N1 * CLASS_SIZE[g] > PAGE_BYTES)) ? N1 - 1 : N1;
    assign cls_count[g] = CNTW'(N2);
    assign cls_start[g] = PAGE_SHIFT'(O1);
  end

  logic [FRAME_W-1:0]    base_frame;
  logic [ADDR_W-1:0]     pool_base;
  logic [PCW-1:0]        claimed;
  logic [CLASS_W-1:0]    cur_cls;
  logic [CNTW-1:0]       cur_count;
  logic [PW-1:0]         cur_page;
  logic [PAGE_SHIFT-1:0] cur_off;
  logic [IW-1:0]         cur_idx;
  logic [PCW-1:0]        issue_p;
  logic [PW-1:0]         check_p;
  logic                  check_valid;
  logic [KW-1:0]         chunk_k;
  logic [CNTW-1:0]       row_used;
  logic [BW-1:0]         row_bits;
  logic [ADDR_W-1:0]     res_addr;
  logic [1:0]            res_status;

  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic [RW-1:0]         ram_wdata;
  logic [PW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  logic [CLASS_W-1:0]    rd_owner;
  logic [CNTW-1:0]       rd_used;
  logic [BW-1:0]         rd_bits;

  logic [CLASS_W-1:0]    size_cls;
  logic [ADDR_W-1:0]     rel;
  logic                  page_match;
  logic [PADW-1:0]       padded;
  logic [CHUNK_W-1:0]    avail;
  soa_scan_t             scan;
  logic [KW+CHUNK_IW-1:0] hit_idx;
  logic [PAGE_SHIFT-1:0] alloc_off;
  logic [CLASS_W-1:0]    own_cls;
  logic [PAGE_SHIFT-1:0] own_start;
  logic [PAGE_SHIFT-1:0] off_d;
  logic [PAGE_SHIFT-1:0] off_mask;
  logic [PAGE_SHIFT-1:0] off_idx;

  soa_ram #(.WIDTH(RW), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  soa_bit_scan u_scan (
    .avail  (avail),
    .result (scan)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign pool_base = {base_frame, {PAGE_SHIFT{1'b0}}};
  assign rd_owner  = ram_rdata[RW-1 -: CLASS_W];
  assign rd_used   = ram_rdata[BW +: CNTW];
  assign rd_bits   = ram_rdata[BW-1:0];
  assign rel       = free_address - pool_base;
  assign page_match = check_valid && (rd_owner == cur_cls + CLASS_W'(1)) &&
                      (rd_used < cur_count);

  always_comb begin
    size_cls = CLASS_W'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (request_size <= SIZE_W'(CLASS_SIZE[c])) begin
        size_cls = CLASS_W'(c);
      end
    end
  end

  always_comb begin
    padded = '1;
    padded[BW-1:0] = row_bits;
    for (int b = 0; b < CHUNK_W; b++) begin
      avail[b] = !padded[int'(chunk_k) * CHUNK_W + b] &&
                 ((int'(chunk_k) * CHUNK_W + b) < int'(cur_count));
    end
    hit_idx   = {chunk_k, scan.idx};
    alloc_off = cls_start[cur_cls] +
                (PAGE_SHIFT'(hit_idx) << CLASS_SHIFT[cur_cls]);
  end

  always_comb begin
    own_cls   = rd_owner - CLASS_W'(1);
    own_start = cls_start[own_cls];
    off_d     = cur_off - own_start;
    off_mask  = (PAGE_SHIFT'(1) << CLASS_SHIFT[own_cls]) - PAGE_SHIFT'(1);
    off_idx   = off_d >> CLASS_SHIFT[own_cls];
  end

  always_comb begin
    ram_raddr = cur_page;
    if (state == S_SCAN) begin
      ram_raddr = issue_p[PW-1:0];
    end
    ram_we    = 1'b0;
    ram_waddr = cur_page;
    ram_wdata = {cur_cls + CLASS_W'(1), row_used, row_bits};
    if (state == S_BITS && scan.hit) begin
      ram_we    = 1'b1;
      ram_wdata = {cur_cls + CLASS_W'(1), row_used + CNTW'(1),
                   row_bits | (BW'(1) << hit_idx)};
    end else if (state == S_FREE_WR && row_bits[cur_idx]) begin
      ram_we    = 1'b1;
      ram_wdata = {cur_cls + CLASS_W'(1),
                   (row_used != '0) ? row_used - CNTW'(1) : row_used,
                   row_bits & ~(BW'(1) << cur_idx)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      base_frame  <= '0;
      claimed     <= '0;
      out_valid   <= 1'b0;
      check_valid <= 1'b0;
    end else begin
      if (out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        base_frame <= pool_base_frame;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_addr    <= '0;
            issue_p     <= '0;
            check_valid <= 1'b0;
            chunk_k     <= '0;
            cur_cls     <= size_cls;
            cur_count   <= cls_count[size_cls];
            cur_page    <= rel[PAGE_SHIFT +: PW];
            cur_off     <= rel[PAGE_SHIFT-1:0];
            if (opcode == OP_ALLOC) begin
              if (request_size == '0 || request_size > SIZE_W'(MAX_SIZE)) begin
                res_status <= ST_BAD_SIZE;
                state      <= S_DONE;
              end else if (cls_count[size_cls] == '0) begin
                res_status <= ST_EXHAUSTED;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (rel[ADDR_W-1:PAGE_SHIFT] >= (ADDR_W-PAGE_SHIFT)'(claimed)) begin
                res_status <= ST_BAD_FREE;
                state      <= S_DONE;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
        end
        S_SCAN: begin
          check_p     <= issue_p[PW-1:0];
          check_valid <= (issue_p < claimed);
          if (issue_p < claimed) begin
            issue_p <= issue_p + PCW'(1);
          end
          if (page_match) begin
            cur_page <= check_p;
            row_used <= rd_used;
            row_bits <= rd_bits;
            state    <= S_BITS;
          end else if (issue_p >= claimed) begin
            if (claimed >= PCW'(NUM_PAGES)) begin
              res_status <= ST_EXHAUSTED;
              state      <= S_DONE;
            end else begin
              cur_page <= claimed[PW-1:0];
              claimed  <= claimed + PCW'(1);
              row_used <= '0;
              row_bits <= '0;
              state    <= S_BITS;
            end
          end
        end
        S_BITS: begin
          if (scan.hit) begin
            res_addr   <= pool_base + {{(ADDR_W-PAGE_SHIFT-PW){1'b0}}, cur_page, alloc_off};
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            chunk_k <= chunk_k + KW'(1);
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          cur_cls    <= own_cls;
          row_used   <= rd_used;
          row_bits   <= rd_bits;
          cur_idx    <= IW'(off_idx);
          res_status <= ST_BAD_FREE;
          if (rd_owner == '0 || cur_off < own_start || (off_d & off_mask) != '0 ||
              off_idx >= PAGE_SHIFT'(cls_count[own_cls])) begin
            state <= S_DONE;
          end else begin
            state <= S_FREE_WR;
          end
        end
        S_FREE_WR: begin
          res_status <= row_bits[cur_idx] ? ST_OK : ST_BAD_FREE;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            object_address <= res_addr;
            status         <= res_status;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/soa_checker.sv]
// Port-level checker for the slab object allocator, bound to the top level.
// Depends on soa_pkg and slab_object_allocator.
`timescale 1ns / 1ps

module soa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [soa_pkg::ADDR_W-1:0]  object_address,
  input logic [1:0]                  status
);
  import soa_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown the cycle after accept");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> object_address == '0)
    else $error("failed item carries an address");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> object_address[1:0] == 2'b00)
    else $error("object address not aligned");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(object_address) && $stable(status))
    else $error("stalled result changed");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);

[tb/sv/tb_slab_object_allocator.sv]
// Self-checking testbench of the slab object allocator: random and directed
// allocate/free items, checked against an in-bench allocator model.
// Depends on soa_pkg and slab_object_allocator.
`timescale 1ns / 1ps

module tb_slab_object_allocator;
  import soa_pkg::*;

  localparam int NPAGES = DEF_NUM_PAGES;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        st;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [FRAME_W-1:0] base_frame;
    logic [3:0]         owner [NPAGES];
    int                 used [NPAGES];
    logic [255:0]       bitmap [NPAGES];
    int                 claimed;
    alloc_result_t      expected_q [$];
    logic [ADDR_W-1:0]  live_rel [$];
    int                 errors;

    function new();
      base_frame = '0;
      claimed = 0;
      errors = 0;
      foreach (owner[p]) begin
        owner[p] = '0;
        used[p] = 0;
        bitmap[p] = '0;
      end
    endfunction

    function void geometry(int c, output int count, output int start);
      int s, a;
      s = CLASS_SIZE[c];
      a = CLASS_ALIGN[c];
      count = (8 * (PAGE_BYTES - DEF_HEADER_BYTES)) / (8 * s + 1);
      if (count > DEF_MAX_OBJECTS) count = DEF_MAX_OBJECTS;
      start = DEF_HEADER_BYTES + (count + 4) / 8;
      if (start % a != 0) begin
        start += a - start % a;
        if (count > 0 && start + count * s > PAGE_BYTES) count--;
      end
    endfunction

    function logic [ADDR_W-1:0] base_addr();
      return {base_frame, 12'h000};
    endfunction

    function alloc_result_t allocate(logic [SIZE_W-1:0] size);
      alloc_result_t r;
      int c, count, start, p;
      bit found;
      r.addr = '0;
      r.st = ST_EXHAUSTED;
      found = 0;
      if (size == 0 || size > MAX_SIZE) begin
        r.st = ST_BAD_SIZE;
        return r;
      end
      c = 0;
      while (c < NUM_CLASSES - 1 && size > CLASS_SIZE[c]) c++;
      geometry(c, count, start);
      if (count == 0) return r;
      for (p = 0; p < claimed; p++) begin
        if (owner[p] == c + 1 && used[p] < count) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        if (claimed >= NPAGES) return r;
        p = claimed++;
        owner[p] = 4'(c + 1);
        used[p] = 0;
        bitmap[p] = '0;
      end
      for (int i = 0; i < count; i++) begin
        if (!bitmap[p][i]) begin
          logic [ADDR_W-1:0] rel;
          bitmap[p][i] = 1'b1;
          used[p]++;
          rel = ADDR_W'(p * PAGE_BYTES + start + CLASS_SIZE[c] * i);
          live_rel.push_back(rel);
          r.addr = base_addr() + rel;
          r.st = ST_OK;
          return r;
        end
      end
      return r;
    endfunction

    function logic [1:0] release_object(logic [ADDR_W-1:0] fa);
      logic [ADDR_W-1:0] rel;
      int p, c, count, start, off, d, i;
      rel = fa - base_addr();
      if (rel[ADDR_W-1:PAGE_SHIFT] >= claimed) return ST_BAD_FREE;
      p = int'(rel[ADDR_W-1:PAGE_SHIFT]);
      if (owner[p] == 0 || owner[p] > NUM_CLASSES) return ST_BAD_FREE;
      c = owner[p] - 1;
      geometry(c, count, start);
      off = rel[PAGE_SHIFT-1:0];
      if (off < start) return ST_BAD_FREE;
      d = off - start;
      if (d % CLASS_SIZE[c] != 0) return ST_BAD_FREE;
      i = d / CLASS_SIZE[c];
      if (i >= count || !bitmap[p][i]) return ST_BAD_FREE;
      bitmap[p][i] = 1'b0;
      if (used[p] > 0) used[p]--;
      foreach (live_rel[k]) begin
        if (live_rel[k] == rel) begin
          live_rel.delete(k);
          break;
        end
      end
      return ST_OK;
    endfunction

    function void note_input(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] fa);
      alloc_result_t r;
      if (op == OP_ALLOC) begin
        r = allocate(size);
      end else begin
        r.addr = '0;
        r.st = release_object(fa);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [1:0] st);
      alloc_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: object_address %h status %0d", addr, st);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (addr !== r.addr) begin
        $error("object_address expected %h got %h", r.addr, addr);
        errors++;
      end
      if (st !== r.st) begin
        $error("status expected %0d got %0d", r.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FRAME_W-1:0]  pool_base_frame;
  logic                in_valid;
  logic                in_ready;
  logic                opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [ADDR_W-1:0]   free_address;
  logic                out_valid;
  logic                out_ready;
  logic [ADDR_W-1:0]   object_address;
  logic [1:0]          status;

  alloc_scoreboard sb;
  bit no_gaps;
  bit hold_request;

  slab_object_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_base_frame(pool_base_frame),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .request_size(request_size), .free_address(free_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .object_address(object_address), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(object_address, status);
  end

  task automatic send_item(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] fa);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    request_size <= size;
    free_address <= fa;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, size, fa);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic write_base(logic [FRAME_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    pool_base_frame <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.base_frame = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] live_address();
    return sb.base_addr() + sb.live_rel[$urandom_range(0, sb.live_rel.size() - 1)];
  endfunction

  task automatic random_item();
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] fa;
    int r, cap;
    cap = (sb.live_rel.size() < 40) ? 60 : 40;
    if (sb.live_rel.size() == 0 || $urandom_range(0, 99) < cap) begin
      r = $urandom_range(0, 99);
      if (r < 70) size = SIZE_W'($urandom_range(1, MAX_SIZE));
      else if (r < 90) size = SIZE_W'(CLASS_SIZE[$urandom_range(0, NUM_CLASSES - 1)]);
      else if (r < 95) size = '0;
      else size = SIZE_W'($urandom_range(MAX_SIZE + 1, 65535));
      send_item(OP_ALLOC, size, ADDR_W'({$urandom, $urandom}));
    end else begin
      r = $urandom_range(0, 99);
      fa = live_address();
      if (r < 80) ;
      else if (r < 85) fa = ADDR_W'({$urandom, $urandom});
      else if (r < 90) fa = fa + $urandom_range(1, 15);
      else if (r < 95) fa[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
      else fa = sb.base_addr() + ADDR_W'($urandom_range(0, NPAGES + 2) * PAGE_BYTES);
      send_item(OP_FREE, SIZE_W'($urandom), fa);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    pool_base_frame = '0;
    in_valid = 1'b0;
    opcode = OP_ALLOC;
    request_size = '0;
    free_address = '0;
    no_gaps = 0;
    hold_request = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_base('0);
    // directed: size edges, every class, each kind of bad free
    send_item(OP_ALLOC, 0, '0);
    send_item(OP_ALLOC, 1, '0);
    send_item(OP_ALLOC, 16, '0);
    send_item(OP_ALLOC, 17, '0);
    send_item(OP_ALLOC, 64, '0);
    send_item(OP_ALLOC, 128, '0);
    send_item(OP_ALLOC, 256, '0);
    send_item(OP_ALLOC, 512, '0);
    send_item(OP_ALLOC, 1024, '0);
    send_item(OP_ALLOC, 1025, '0);
    send_item(OP_ALLOC, 16'hffff, '0);
    a = sb.base_addr() + sb.live_rel[0];
    send_item(OP_FREE, '0, a + 4);
    send_item(OP_FREE, '0, a);
    send_item(OP_FREE, '0, a);
    send_item(OP_FREE, '0, sb.base_addr());
    send_item(OP_FREE, '0, sb.base_addr() + 48'd40 * PAGE_BYTES + 100);
    send_item(OP_FREE, '0, '1);
    send_item(OP_FREE, '0, sb.base_addr() + 48'd6 * PAGE_BYTES + 64 + 3 * 1024);
    send_item(OP_FREE, '0, sb.base_addr() + 48'd6 * PAGE_BYTES + 64 + 1024);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_base('1);
        1: write_base(FRAME_W'({$urandom, $urandom}));
        2: write_base(FRAME_W'($urandom_range(0, 15)));
        default: write_base(FRAME_W'({$urandom, $urandom}));
      endcase
      no_gaps = (ph == 2);
      for (int n = 0; n < 420; n++) begin
        if (ph == 1 && n == 100) hold_request = 1;
        random_item();
      end
    end

    // fill the pool until exhausted, then free and reuse
    drain();
    for (int n = 0; n < 200; n++) begin
      send_item(OP_ALLOC, SIZE_W'($urandom_range(513, 1024)), '0);
    end
    for (int n = 0; n < 40; n++) begin
      if (sb.live_rel.size() > 0) send_item(OP_FREE, '0, live_address());
      send_item(OP_ALLOC, SIZE_W'($urandom_range(1, MAX_SIZE)), '0);
    end

    drain();
    if (sb.expected_q.size() != 0) begin
      $error("%0d results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
